@@ design/pktdd_pkg.sv @@
// Package with shared constants, codes and types of the packet FIFO with duplicate filter.
package pktdd_pkg;

   localparam int DEPTH      = 64;
   localparam int ID_WIDTH   = 16;
   localparam int TIME_WIDTH = 32;

   localparam int CAP_WIDTH   = 7;
   localparam int COUNT_WIDTH = 7;
   localparam int MODE_WIDTH  = 2;

   localparam logic [CAP_WIDTH-1:0]   CAP_RESET = 7'd64;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 7'd127;

   localparam logic [MODE_WIDTH-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_FORWARD = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_COUNT   = 2'd2;

   typedef struct packed {
      logic shift;
      logic write;
      logic add_mode;
   } cell_ctrl_type;

endpackage

@@ design/pktdd_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
interface pktdd_req_if #(
   parameter int ID_WIDTH   = pktdd_pkg::ID_WIDTH,
   parameter int TIME_WIDTH = pktdd_pkg::TIME_WIDTH
);
   logic                                valid;
   logic                                ready;
   logic [pktdd_pkg::MODE_WIDTH-1:0]    mode;
   logic [ID_WIDTH-1:0]                 source;
   logic [ID_WIDTH-1:0]                 destination;
   logic [TIME_WIDTH-1:0]               timestamp;
   logic [TIME_WIDTH-1:0]               start_time;
   logic [TIME_WIDTH-1:0]               end_time;

   modport source_mp (output valid, mode, source, destination, timestamp, start_time,
                      end_time, input ready);
   modport sink_mp (input valid, mode, source, destination, timestamp, start_time,
                    end_time, output ready);
endinterface

interface pktdd_rsp_if #(
   parameter int ID_WIDTH   = pktdd_pkg::ID_WIDTH,
   parameter int TIME_WIDTH = pktdd_pkg::TIME_WIDTH
);
   logic                                 valid;
   logic                                 ready;
   logic                                 accepted;
   logic                                 packet_valid;
   logic [ID_WIDTH-1:0]                  out_source;
   logic [ID_WIDTH-1:0]                  out_destination;
   logic [TIME_WIDTH-1:0]                out_timestamp;
   logic [pktdd_pkg::COUNT_WIDTH-1:0]    match_count;

   modport source_mp (output valid, accepted, packet_valid, out_source, out_destination,
                      out_timestamp, match_count, input ready);
   modport sink_mp (input valid, accepted, packet_valid, out_source, out_destination,
                    out_timestamp, match_count, output ready);
endinterface

@@ design/packet_fifo_dedup_range_count.sv @@
// Top level of the bounded packet FIFO with duplicate filter and range count.
//
//  Channel   Direction  Handshake             Contents
//  req_chan  in         valid/ready           mode, packet fields, time bounds
//  rsp_chan  out        valid/ready           accepted, popped packet, match count
//  csr_*     in         write enable only     capacity limit
//
// A forward pops the oldest packet, if there is one. A count or a duplicate add ends once the
// match count has rippled through the chain one cell per cycle. An accepted add then evicts
// the oldest packets one by one while the FIFO is at its limit, then writes. A new request
// transaction is taken once the previous result sits in the output register, so a stalled
// response holds off the next request. Reset is synchronous and leaves the FIFO empty.
module packet_fifo_dedup_range_count #(
   parameter int DEPTH      = pktdd_pkg::DEPTH,
   parameter int ID_WIDTH   = pktdd_pkg::ID_WIDTH,
   parameter int TIME_WIDTH = pktdd_pkg::TIME_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   pktdd_req_if.sink_mp                        req_chan,
   pktdd_rsp_if.source_mp                      rsp_chan,
   input  logic                                csr_we,
   input  logic [pktdd_pkg::CAP_WIDTH-1:0]     csr_wdata
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CNT_W = OCC_W;
   localparam int CMP_W = (OCC_W > pktdd_pkg::CAP_WIDTH) ? OCC_W : pktdd_pkg::CAP_WIDTH;
   localparam int SAT_W = (CNT_W > pktdd_pkg::COUNT_WIDTH) ? CNT_W : pktdd_pkg::COUNT_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_DROP = 5'b00100,
      ST_DONE = 5'b01000,
      ST_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [pktdd_pkg::CAP_WIDTH-1:0]  cap_ff;
   logic [OCC_W-1:0]                 occ_ff, occ_in;
   logic                             start_ff, start_in;
   logic [pktdd_pkg::MODE_WIDTH-1:0] q_mode_ff;
   logic [ID_WIDTH-1:0]              q_src_ff, q_dst_ff;
   logic [TIME_WIDTH-1:0]            q_ts_ff, q_t0_ff, q_t1_ff;

   logic                             res_acc_ff, res_acc_in;
   logic                             res_pv_ff, res_pv_in;
   logic [ID_WIDTH-1:0]              res_src_ff, res_src_in;
   logic [ID_WIDTH-1:0]              res_dst_ff, res_dst_in;
   logic [TIME_WIDTH-1:0]            res_ts_ff, res_ts_in;
   logic [pktdd_pkg::COUNT_WIDTH-1:0] res_cnt_ff, res_cnt_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_acc_ff, rsp_pv_ff;
   logic [ID_WIDTH-1:0]              rsp_src_ff, rsp_dst_ff;
   logic [TIME_WIDTH-1:0]            rsp_ts_ff;
   logic [pktdd_pkg::COUNT_WIDTH-1:0] rsp_cnt_ff;

   pktdd_pkg::cell_ctrl_type         ctrl;
   logic                             req_take;
   logic                             rsp_load;
   logic [CMP_W-1:0]                 limit;
   logic [CMP_W-1:0]                 cap_ext;
   logic [SAT_W-1:0]                 cnt_ext;
   logic [pktdd_pkg::COUNT_WIDTH-1:0] cnt_sat;

   logic                             tok_w [DEPTH+1];
   logic [CNT_W-1:0]                 cnt_w [DEPTH+1];
   logic [ID_WIDTH-1:0]              ent_src [DEPTH];
   logic [ID_WIDTH-1:0]              ent_dst [DEPTH];
   logic [TIME_WIDTH-1:0]            ent_ts [DEPTH];

   assign tok_w[0] = start_ff;
   assign cnt_w[0] = '0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam int NB = (k == DEPTH - 1) ? k : k + 1;
      pktdd_cell #(
         .IDX        (k),
         .ID_WIDTH   (ID_WIDTH),
         .TIME_WIDTH (TIME_WIDTH),
         .OCC_W      (OCC_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl),
         .occupancy       (occ_ff),
         .q_source        (q_src_ff),
         .q_destination   (q_dst_ff),
         .q_timestamp     (q_ts_ff),
         .q_start_time    (q_t0_ff),
         .q_end_time      (q_t1_ff),
         .nb_source       (ent_src[NB]),
         .nb_destination  (ent_dst[NB]),
         .nb_timestamp    (ent_ts[NB]),
         .tok_i           (tok_w[k]),
         .cnt_i           (cnt_w[k]),
         .tok_o           (tok_w[k+1]),
         .cnt_o           (cnt_w[k+1]),
         .ent_source      (ent_src[k]),
         .ent_destination (ent_dst[k]),
         .ent_timestamp   (ent_ts[k])
      );
   end

   assign cap_ext = CMP_W'(cap_ff);
   always_comb begin
      if (cap_ext == '0) begin
         limit = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         limit = CMP_W'(DEPTH);
      end else begin
         limit = cap_ext;
      end
   end

   assign cnt_ext = SAT_W'(cnt_w[DEPTH]);
   assign cnt_sat = (cnt_ext > SAT_W'(pktdd_pkg::COUNT_MAX)) ? pktdd_pkg::COUNT_MAX :
                    cnt_ext[pktdd_pkg::COUNT_WIDTH-1:0];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      start_in      = 1'b0;
      ctrl.shift    = 1'b0;
      ctrl.write    = 1'b0;
      ctrl.add_mode = (q_mode_ff == pktdd_pkg::MODE_ADD);
      res_acc_in    = res_acc_ff;
      res_pv_in     = res_pv_ff;
      res_src_in    = res_src_ff;
      res_dst_in    = res_dst_ff;
      res_ts_in     = res_ts_ff;
      res_cnt_in    = res_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_acc_in = 1'b0;
               res_pv_in  = 1'b0;
               res_src_in = '0;
               res_dst_in = '0;
               res_ts_in  = '0;
               res_cnt_in = '0;
               unique case (req_chan.mode) inside
                  pktdd_pkg::MODE_ADD, pktdd_pkg::MODE_COUNT: begin
                     start_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  pktdd_pkg::MODE_FORWARD: begin
                     if (occ_ff != '0) begin
                        res_pv_in  = 1'b1;
                        res_src_in = ent_src[0];
                        res_dst_in = ent_dst[0];
                        res_ts_in  = ent_ts[0];
                        ctrl.shift = 1'b1;
                        occ_in     = occ_ff - OCC_W'(1);
                     end
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (tok_w[DEPTH]) begin
               if (q_mode_ff == pktdd_pkg::MODE_ADD) begin
                  state_in = (cnt_w[DEPTH] != '0) ? ST_DONE : ST_DROP;
               end else begin
                  res_cnt_in = cnt_sat;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DROP: begin
            if (CMP_W'(occ_ff) >= limit) begin
               ctrl.shift = 1'b1;
               occ_in     = occ_ff - OCC_W'(1);
            end else begin
               ctrl.write = 1'b1;
               occ_in     = occ_ff + OCC_W'(1);
               res_acc_in = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= pktdd_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         q_mode_ff <= req_chan.mode;
         q_src_ff  <= req_chan.source;
         q_dst_ff  <= req_chan.destination;
         q_ts_ff   <= req_chan.timestamp;
         q_t0_ff   <= req_chan.start_time;
         q_t1_ff   <= req_chan.end_time;
      end
      res_acc_ff <= res_acc_in;
      res_pv_ff  <= res_pv_in;
      res_src_ff <= res_src_in;
      res_dst_ff <= res_dst_in;
      res_ts_ff  <= res_ts_in;
      res_cnt_ff <= res_cnt_in;
      if (rsp_load) begin
         rsp_acc_ff <= res_acc_ff;
         rsp_pv_ff  <= res_pv_ff;
         rsp_src_ff <= res_src_ff;
         rsp_dst_ff <= res_dst_ff;
         rsp_ts_ff  <= res_ts_ff;
         rsp_cnt_ff <= res_cnt_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accepted        = rsp_acc_ff;
   assign rsp_chan.packet_valid    = rsp_pv_ff;
   assign rsp_chan.out_source      = rsp_src_ff;
   assign rsp_chan.out_destination = rsp_dst_ff;
   assign rsp_chan.out_timestamp   = rsp_ts_ff;
   assign rsp_chan.match_count     = rsp_cnt_ff;

endmodule

@@ design/pktdd_cell.sv @@
// One storage cell of the packet chain: holds a packet, compares it and adds to the running count.
module pktdd_cell #(
   parameter int IDX        = 0,
   parameter int ID_WIDTH   = pktdd_pkg::ID_WIDTH,
   parameter int TIME_WIDTH = pktdd_pkg::TIME_WIDTH,
   parameter int OCC_W      = 7,
   parameter int CNT_W      = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pktdd_pkg::cell_ctrl_type ctrl,
   input  logic [OCC_W-1:0]         occupancy,
   input  logic [ID_WIDTH-1:0]      q_source,
   input  logic [ID_WIDTH-1:0]      q_destination,
   input  logic [TIME_WIDTH-1:0]    q_timestamp,
   input  logic [TIME_WIDTH-1:0]    q_start_time,
   input  logic [TIME_WIDTH-1:0]    q_end_time,
   input  logic [ID_WIDTH-1:0]      nb_source,
   input  logic [ID_WIDTH-1:0]      nb_destination,
   input  logic [TIME_WIDTH-1:0]    nb_timestamp,
   input  logic                     tok_i,
   input  logic [CNT_W-1:0]         cnt_i,
   output logic                     tok_o,
   output logic [CNT_W-1:0]         cnt_o,
   output logic [ID_WIDTH-1:0]      ent_source,
   output logic [ID_WIDTH-1:0]      ent_destination,
   output logic [TIME_WIDTH-1:0]    ent_timestamp
);

   logic [ID_WIDTH-1:0]   src_ff;
   logic [ID_WIDTH-1:0]   dst_ff;
   logic [TIME_WIDTH-1:0] ts_ff;
   logic                  tok_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic                  live;
   logic                  hit_dup;
   logic                  hit_cnt;
   logic                  hit;

   assign live    = occupancy > OCC_W'(IDX);
   assign hit_dup = live && (src_ff == q_source) && (dst_ff == q_destination) &&
                    (ts_ff == q_timestamp);
   assign hit_cnt = live && (dst_ff == q_destination) && (ts_ff >= q_start_time) &&
                    (ts_ff <= q_end_time);
   assign hit     = ctrl.add_mode ? hit_dup : hit_cnt;
   assign cnt_in  = cnt_i + CNT_W'(hit);

   always_ff @(posedge clock) begin
      if (ctrl.write && (occupancy == OCC_W'(IDX))) begin
         src_ff <= q_source;
         dst_ff <= q_destination;
         ts_ff  <= q_timestamp;
      end else if (ctrl.shift) begin
         src_ff <= nb_source;
         dst_ff <= nb_destination;
         ts_ff  <= nb_timestamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   assign tok_o           = tok_ff;
   assign cnt_o           = cnt_ff;
   assign ent_source      = src_ff;
   assign ent_destination = dst_ff;
   assign ent_timestamp   = ts_ff;

endmodule

@@ dv/tb_packet_fifo_dedup_range_count.sv @@
// Self-checking testbench for the bounded packet FIFO with duplicate filter and range count.
module tb_packet_fifo_dedup_range_count;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pktdd_pkg::MODE_WIDTH-1:0] MODE_IDLE    = 2'd3;
   localparam int unsigned                      CYCLE_LIMIT  = 1000000;
   localparam int unsigned                      DRAIN_CYCLES = 2 * pktdd_pkg::DEPTH + 8;
   localparam logic [pktdd_pkg::ID_WIDTH-1:0]   ID_MAX       = '1;
   localparam logic [pktdd_pkg::TIME_WIDTH-1:0] TIME_MAX     = '1;
   localparam logic [pktdd_pkg::ID_WIDTH-1:0]   DEST_NARROW  = 16'h5A5A;
   localparam int unsigned                      PHASES       = 12;

   typedef struct packed {
      logic [pktdd_pkg::MODE_WIDTH-1:0] mode;
      logic [pktdd_pkg::ID_WIDTH-1:0]   source;
      logic [pktdd_pkg::ID_WIDTH-1:0]   destination;
      logic [pktdd_pkg::TIME_WIDTH-1:0] timestamp;
      logic [pktdd_pkg::TIME_WIDTH-1:0] start_time;
      logic [pktdd_pkg::TIME_WIDTH-1:0] end_time;
   } request_type;

   typedef struct packed {
      logic                              accepted;
      logic                              packet_valid;
      logic [pktdd_pkg::ID_WIDTH-1:0]    out_source;
      logic [pktdd_pkg::ID_WIDTH-1:0]    out_destination;
      logic [pktdd_pkg::TIME_WIDTH-1:0]  out_timestamp;
      logic [pktdd_pkg::COUNT_WIDTH-1:0] match_count;
   } outcome_type;

   typedef struct packed {
      request_type req;
      logic        typed;
      outcome_type want;
   } script_row_type;

   typedef struct packed {
      logic [pktdd_pkg::CAP_WIDTH-1:0] cap;
      int unsigned                     items;
      int unsigned                     add_pct;
      int unsigned                     fwd_pct;
      bit                              narrow;
      bit                              quiet;
   } phase_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [pktdd_pkg::CAP_WIDTH-1:0] csr_wdata;

   pktdd_req_if req_chan ();
   pktdd_rsp_if rsp_chan ();

   packet_fifo_dedup_range_count u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [pktdd_pkg::ID_WIDTH-1:0]   held_source      [pktdd_pkg::DEPTH];
   logic [pktdd_pkg::ID_WIDTH-1:0]   held_destination [pktdd_pkg::DEPTH];
   logic [pktdd_pkg::TIME_WIDTH-1:0] held_time        [pktdd_pkg::DEPTH];
   int unsigned                      oldest_slot = 0;
   int unsigned                      held_count  = 0;
   logic [pktdd_pkg::CAP_WIDTH-1:0]  capacity    = pktdd_pkg::CAP_RESET;

   outcome_type pending_outcomes [$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          quiet = 1'b0;

   script_row_type script [20] = '{
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '0},
      '{'{pktdd_pkg::MODE_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, TIME_MAX}, 1'b1, '0},
      '{'{pktdd_pkg::MODE_ADD, ID_MAX, ID_MAX, TIME_MAX, 32'h0, 32'h0}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
      '{'{pktdd_pkg::MODE_ADD, ID_MAX, ID_MAX, TIME_MAX, TIME_MAX, TIME_MAX}, 1'b1, '0},
      '{'{pktdd_pkg::MODE_ADD, 16'h0, 16'h0, 32'h0, TIME_MAX, 32'h0}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
      '{'{pktdd_pkg::MODE_ADD, 16'h0, ID_MAX, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
      '{'{pktdd_pkg::MODE_ADD, ID_MAX, 16'h0, TIME_MAX, 32'h0, 32'h0}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
      '{'{pktdd_pkg::MODE_COUNT, 16'h0, ID_MAX, 32'h0, 32'h0, TIME_MAX}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd2}},
      '{'{pktdd_pkg::MODE_COUNT, 16'h0, ID_MAX, 32'h0, TIME_MAX, 32'h0}, 1'b1, '0},
      '{'{pktdd_pkg::MODE_COUNT, 16'h0, ID_MAX, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd1}},
      '{'{pktdd_pkg::MODE_COUNT, 16'h0, ID_MAX, 32'h0, TIME_MAX, TIME_MAX}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd1}},
      '{'{pktdd_pkg::MODE_COUNT, ID_MAX, 16'h0, TIME_MAX, 32'h1, 32'hFFFF_FFFE}, 1'b0, '0},
      '{'{MODE_IDLE, ID_MAX, ID_MAX, TIME_MAX, TIME_MAX, TIME_MAX}, 1'b1, '0},
      '{'{pktdd_pkg::MODE_ADD, 16'hA5A5, 16'h5A5A, 32'hA5A5_5A5A, 32'h0, 32'h0}, 1'b0, '0},
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b0, 1'b1, ID_MAX, ID_MAX, TIME_MAX, 7'd0}},
      '{'{pktdd_pkg::MODE_FORWARD, ID_MAX, ID_MAX, TIME_MAX, TIME_MAX, TIME_MAX}, 1'b1,
        '{1'b0, 1'b1, 16'h0, 16'h0, 32'h0, 7'd0}},
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{pktdd_pkg::MODE_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '0}
   };

   // The narrow phases put one destination in every slot so that counts can reach a full store,
   // and the low capacity that follows a full store forces a multi-packet eviction.
   phase_type plan [PHASES] = '{
      '{7'd64,  90, 50, 25, 1'b0, 1'b0},
      '{7'd1,   50, 50, 25, 1'b0, 1'b0},
      '{7'd0,   40, 50, 25, 1'b0, 1'b1},
      '{7'd127, 100, 90, 3, 1'b1, 1'b0},
      '{7'd4,   40, 50, 20, 1'b0, 1'b0},
      '{7'd2,   50, 45, 30, 1'b0, 1'b0},
      '{7'd64,  80, 70, 10, 1'b0, 1'b1},
      '{7'd5,   50, 50, 25, 1'b0, 1'b0},
      '{7'd100, 70, 40, 35, 1'b0, 1'b0},
      '{7'd3,   50, 45, 30, 1'b0, 1'b0},
      '{7'd16,  60, 55, 20, 1'b0, 1'b0},
      '{7'd64,  100, 85, 5, 1'b1, 1'b0}
   };

   function automatic outcome_type apply_operation(input request_type r);
      outcome_type res;
      int unsigned limit;
      int unsigned slot;
      int unsigned hits;
      int unsigned i;
      bit          dup;
      res  = '0;
      dup  = 1'b0;
      hits = 0;
      unique case (r.mode)
         pktdd_pkg::MODE_ADD: begin
            for (i = 0; i < held_count; i++) begin
               slot = (oldest_slot + i) % pktdd_pkg::DEPTH;
               if (held_source[slot] == r.source && held_destination[slot] == r.destination &&
                   held_time[slot] == r.timestamp) begin
                  dup = 1'b1;
               end
            end
            if (!dup) begin
               limit = (capacity == 0) ? 1 :
                       ((capacity > pktdd_pkg::DEPTH) ? pktdd_pkg::DEPTH : int'(capacity));
               if (held_count >= limit) begin
                  oldest_slot = (oldest_slot + held_count - limit + 1) % pktdd_pkg::DEPTH;
                  held_count  = limit - 1;
               end
               slot = (oldest_slot + held_count) % pktdd_pkg::DEPTH;
               held_source[slot]      = r.source;
               held_destination[slot] = r.destination;
               held_time[slot]        = r.timestamp;
               held_count++;
               res.accepted = 1'b1;
            end
         end
         pktdd_pkg::MODE_FORWARD: begin
            if (held_count > 0) begin
               res.packet_valid    = 1'b1;
               res.out_source      = held_source[oldest_slot];
               res.out_destination = held_destination[oldest_slot];
               res.out_timestamp   = held_time[oldest_slot];
               oldest_slot = (oldest_slot + 1) % pktdd_pkg::DEPTH;
               held_count--;
            end
         end
         pktdd_pkg::MODE_COUNT: begin
            if (r.start_time <= r.end_time) begin
               for (i = 0; i < held_count; i++) begin
                  slot = (oldest_slot + i) % pktdd_pkg::DEPTH;
                  if (held_destination[slot] == r.destination && held_time[slot] >= r.start_time &&
                      held_time[slot] <= r.end_time) begin
                     hits++;
                  end
               end
            end
            res.match_count = (hits > pktdd_pkg::COUNT_MAX) ? pktdd_pkg::COUNT_MAX :
                              pktdd_pkg::COUNT_WIDTH'(hits);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic int unsigned draw_wait();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic int unsigned random_slot();
      return (oldest_slot + $urandom_range(0, held_count - 1)) % pktdd_pkg::DEPTH;
   endfunction

   function automatic request_type draw_request(input int unsigned add_pct,
                                                input int unsigned fwd_pct, input bit narrow);
      request_type r;
      int unsigned roll;
      int unsigned slot;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
         r.mode = pktdd_pkg::MODE_ADD;
      end else if (roll < add_pct + fwd_pct) begin
         r.mode = pktdd_pkg::MODE_FORWARD;
      end else if (roll < 97) begin
         r.mode = pktdd_pkg::MODE_COUNT;
      end else begin
         r.mode = MODE_IDLE;
      end
      r.source      = pktdd_pkg::ID_WIDTH'($urandom);
      r.destination = pktdd_pkg::ID_WIDTH'($urandom);
      r.timestamp   = pktdd_pkg::TIME_WIDTH'($urandom);
      r.start_time  = pktdd_pkg::TIME_WIDTH'($urandom);
      r.end_time    = pktdd_pkg::TIME_WIDTH'($urandom);
      if (r.mode == pktdd_pkg::MODE_ADD) begin
         if (held_count > 0 && $urandom_range(0, 3) == 0) begin
            slot          = random_slot();
            r.source      = held_source[slot];
            r.destination = held_destination[slot];
            r.timestamp   = held_time[slot];
         end else begin
            if ($urandom_range(0, 3) != 0) begin
               r.source = pktdd_pkg::ID_WIDTH'($urandom_range(0, 3));
            end
            if (narrow) begin
               r.destination = DEST_NARROW;
            end else if ($urandom_range(0, 9) < 7) begin
               r.destination = pktdd_pkg::ID_WIDTH'($urandom_range(0, 3));
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
               r.timestamp = pktdd_pkg::TIME_WIDTH'($urandom_range(0, 40));
            end else if (roll < 8) begin
               r.timestamp = TIME_MAX - pktdd_pkg::TIME_WIDTH'($urandom_range(0, 3));
            end
         end
      end else if (r.mode == pktdd_pkg::MODE_COUNT) begin
         if (narrow) begin
            r.destination = DEST_NARROW;
         end else if (held_count > 0 && $urandom_range(0, 9) < 6) begin
            r.destination = held_destination[random_slot()];
         end else if ($urandom_range(0, 1) == 0) begin
            r.destination = pktdd_pkg::ID_WIDTH'($urandom_range(0, 3));
         end
         roll = $urandom_range(0, 9);
         if (roll == 0 || (narrow && roll < 5)) begin
            r.start_time = '0;
            r.end_time   = TIME_MAX;
         end else if (roll == 1) begin
            r.end_time   = pktdd_pkg::TIME_WIDTH'($urandom_range(0, 40));
            r.start_time = r.end_time + pktdd_pkg::TIME_WIDTH'($urandom_range(1, 20));
         end else if (roll > 2) begin
            r.start_time = pktdd_pkg::TIME_WIDTH'($urandom_range(0, 30));
            r.end_time   = r.start_time + pktdd_pkg::TIME_WIDTH'($urandom_range(0, 20));
         end
      end
      return r;
   endfunction

   task automatic send_request(input request_type r, input logic typed,
                               input outcome_type want);
      int unsigned gap;
      outcome_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= r.mode;
      req_chan.source      <= r.source;
      req_chan.destination <= r.destination;
      req_chan.timestamp   <= r.timestamp;
      req_chan.start_time  <= r.start_time;
      req_chan.end_time    <= r.end_time;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = apply_operation(r);
      pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
   endtask

   task automatic wait_drained(input int unsigned settle);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[packet_fifo_dedup_range_count] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = '{rsp_chan.accepted, rsp_chan.packet_valid, rsp_chan.out_source,
                 rsp_chan.out_destination, rsp_chan.out_timestamp, rsp_chan.match_count};
         if (pending_outcomes.size() == 0) begin
            $display("%0t ns: unexpected transaction, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(got.accepted));
            check_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
            check_field("out_source", 32'(want.out_source), 32'(got.out_source));
            check_field("out_destination", 32'(want.out_destination), 32'(got.out_destination));
            check_field("out_timestamp", want.out_timestamp, got.out_timestamp);
            check_field("match_count", 32'(want.match_count), 32'(got.match_count));
         end
      end
   end

   initial begin
      int unsigned p;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.mode        <= pktdd_pkg::MODE_ADD;
      req_chan.source      <= '0;
      req_chan.destination <= '0;
      req_chan.timestamp   <= '0;
      req_chan.start_time  <= '0;
      req_chan.end_time    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         send_request(script[k].req, script[k].typed, script[k].want);
      end

      for (p = 0; p < PHASES; p++) begin
         req_chan.valid <= 1'b0;
         wait_drained(4);
         quiet = plan[p].quiet;
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= plan[p].cap;
         capacity = plan[p].cap;
         @(posedge clock);
         csr_we <= 1'b0;
         repeat (plan[p].items) begin
            send_request(draw_request(plan[p].add_pct, plan[p].fwd_pct, plan[p].narrow),
                         1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained(DRAIN_CYCLES);
      if (mismatches == 0) begin
         $display("[packet_fifo_dedup_range_count] OK");
      end else begin
         $display("[packet_fifo_dedup_range_count] ERROR");
      end
      $finish;
   end

endmodule
